// ===== hdl/ffea_pkg.sv =====
// Shared types and constants of the first-fit extent allocator.
package ffea_pkg;

    localparam int ADDR_W             = 32;
    localparam int DEF_MAX_EXTENTS    = 64;
    localparam logic [31:0] RESET_INITIAL_SIZE = 32'(1024 * 4);
    localparam logic [31:0] RESET_GROW_STEP    = 32'(1024 * 1024);
    localparam logic [31:0] RESET_HEAP_LIMIT   = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_OVERLAP  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
    localparam logic [1:0] REG_INITIAL_SIZE = 2'd1;
    localparam logic [1:0] REG_GROW_STEP    = 2'd2;
    localparam logic [1:0] REG_HEAP_LIMIT   = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] length;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] ext_start;
        logic [ADDR_W-1:0] ext_end;
    } t_extent;

endpackage

// ===== hdl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: sequencer, extent table and registers.
//
// Usage: drive a request (mode, address, length) on i_request and raise start
// while busy is low; the request is taken at that clock edge and busy rises.
// Allocate (mode 0) returns the granted start address, free (mode 1) returns
// only a status. Exactly one result per request appears on o_result for one
// cycle, marked by o_result_valid; the receiver cannot stall it, and busy falls
// in the cycle after the strobe, so a new request can be taken right after.
// Sequence: the sequencer walks the extent table one extent at a time through its
// registered read port. An allocate takes the first extent that fits; using an
// extent up shifts the later extents down. When nothing fits, growth runs a
// bit-serial remainder loop. A free scans the extents below the address, then
// inserts (shifting extents up) or bridges neighbours and drops the right one.
// The first request after reset first loads the initial extent; one request at a time.
// Configuration goes through the APB port (heap_base, initial_size, grow_step,
// heap_limit at byte offsets 0, 4, 8, 12). The user must write it only while
// idle; the block itself does not enforce this.
// Reset clears the control state and empties the table; the first request
// after reset loads the initial extent [heap_base, heap_base+initial_size).
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffea_pkg::DEF_MAX_EXTENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ffea_pkg::t_request i_request,
    output logic               o_result_valid,
    output ffea_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AW = ffea_pkg::ADDR_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_A_RD  = 5'd2;
    localparam logic [4:0] S_A_CHK = 5'd3;
    localparam logic [4:0] S_NOFIT = 5'd4;
    localparam logic [4:0] S_DIV   = 5'd5;
    localparam logic [4:0] S_G1    = 5'd6;
    localparam logic [4:0] S_G2    = 5'd7;
    localparam logic [4:0] S_F_PRE = 5'd8;
    localparam logic [4:0] S_F_RD  = 5'd9;
    localparam logic [4:0] S_F_CHK = 5'd10;
    localparam logic [4:0] S_F_DEC = 5'd11;
    localparam logic [4:0] S_RM_RD = 5'd12;
    localparam logic [4:0] S_RM_WR = 5'd13;
    localparam logic [4:0] S_IN_RD = 5'd14;
    localparam logic [4:0] S_IN_WR = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    localparam logic [1:0] REG_HEAP_BASE_C = ffea_pkg::REG_HEAP_BASE;
    localparam logic [1:0] REG_INIT_C      = ffea_pkg::REG_INITIAL_SIZE;
    localparam logic [1:0] REG_STEP_C      = ffea_pkg::REG_GROW_STEP;

    // Configuration registers
    logic [31:0] r_heap_base, r_init_size, r_grow_step, r_heap_limit;

    // Control state
    logic [4:0]    r_state, n_state;
    logic          r_started, n_started;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_top, n_top;

    // Working registers of the current request
    logic               r_mode, n_mode;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_len, n_len;
    logic [AW-1:0]      r_fend, n_fend;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_k, n_k;
    ffea_pkg::t_extent  r_cur, n_cur;
    ffea_pkg::t_extent  r_right, n_right;
    logic               r_rvalid, n_rvalid;
    logic               r_touch, n_touch;
    logic [AW-1:0]      r_need, n_need;
    logic [AW-1:0]      r_step, n_step;
    logic [AW-1:0]      r_rem, n_rem;
    logic [4:0]         r_bit, n_bit;
    logic [AW+1:0]      r_grow, n_grow;
    ffea_pkg::t_result  r_res, n_res;

    // Extent table: one write and one registered read per cycle
    ffea_pkg::t_extent r_mem [MAX_EXTENTS];
    ffea_pkg::t_extent r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_wa, mem_ra;
    ffea_pkg::t_extent mem_wd;

    // Helpers
    logic [CW-1:0] idx_p1, idx_m1, k_m1, cnt_m1;
    logic [AW-1:0] sz_lim, room, sz;
    logic [AW:0]   rem2, fend_w;
    logic [AW+1:0] top_sum;
    logic [AW-1:0] new_top, ext_s, cut_s, hsize;
    logic          at_cap, cfg_wr;

    assign idx_p1 = r_idx + 1'b1;
    assign idx_m1 = r_idx - 1'b1;
    assign k_m1   = r_k - 1'b1;
    assign cnt_m1 = r_count - 1'b1;
    assign at_cap = (r_count >= CW'(MAX_EXTENTS));

    // Start-up sizing: clip to the limit and to the top of the address space
    assign sz_lim = (r_init_size > r_heap_limit) ? r_heap_limit : r_init_size;
    assign room   = '1 - r_heap_base;
    assign sz     = (sz_lim > room) ? room : sz_lim;

    // One remainder step of need / step
    assign rem2   = {r_rem, r_need[r_bit]};
    assign fend_w = {1'b0, r_addr} + {1'b0, r_len};

    // Growth: new top and the extent the request is cut from
    assign top_sum = {2'b00, r_top} + r_grow;
    assign new_top = top_sum[AW-1:0];
    assign hsize   = (new_top >= r_heap_base) ? (new_top - r_heap_base) : '0;
    assign ext_s   = r_touch ? r_cur.ext_start : r_top;
    assign cut_s   = ext_s + r_len;

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);
    assign o_result       = r_res;
    assign pready         = 1'b1;
    assign cfg_wr         = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_HEAP_BASE_C:    prdata = r_heap_base;
            REG_INIT_C:         prdata = r_init_size;
            REG_STEP_C:         prdata = r_grow_step;
            default:            prdata = r_heap_limit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_init_size  <= ffea_pkg::RESET_INITIAL_SIZE;
            r_grow_step  <= ffea_pkg::RESET_GROW_STEP;
            r_heap_limit <= ffea_pkg::RESET_HEAP_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ffea_pkg::REG_HEAP_BASE:    r_heap_base  <= pwdata;
                ffea_pkg::REG_INITIAL_SIZE: r_init_size  <= pwdata;
                ffea_pkg::REG_GROW_STEP:    r_grow_step  <= pwdata;
                default:                    r_heap_limit <= pwdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_count   = r_count;
        n_top     = r_top;
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_len     = r_len;
        n_fend    = r_fend;
        n_idx     = r_idx;
        n_k       = r_k;
        n_cur     = r_cur;
        n_right   = r_right;
        n_rvalid  = r_rvalid;
        n_touch   = r_touch;
        n_need    = r_need;
        n_step    = r_step;
        n_rem     = r_rem;
        n_bit     = r_bit;
        n_grow    = r_grow;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_wa    = r_idx[IW-1:0];
        mem_ra    = r_idx[IW-1:0];
        mem_wd    = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_request.mode;
                    n_addr = i_request.address;
                    n_len  = i_request.length;
                    n_idx  = '0;
                    n_res  = '{granted_address: '0, status: ffea_pkg::ST_OK};
                    if (!r_started) begin
                        n_state = S_INIT;
                    end else if (i_request.mode == ffea_pkg::MODE_FREE) begin
                        n_state = S_F_PRE;
                    end else begin
                        n_state = S_A_RD;
                    end
                end
            end
            S_INIT: begin
                // Load the initial extent, if any
                n_started = 1'b1;
                n_top     = r_heap_base + sz;
                n_count   = (sz != '0) ? CW'(1) : '0;
                mem_we    = (sz != '0);
                mem_wa    = '0;
                mem_wd    = '{ext_start: r_heap_base, ext_end: r_heap_base + sz};
                n_state   = (r_mode == ffea_pkg::MODE_FREE) ? S_F_PRE : S_A_RD;
            end
            S_A_RD: begin
                n_state = (r_idx < r_count) ? S_A_CHK : S_NOFIT;
            end
            S_A_CHK: begin
                if ((r_rdata.ext_end - r_rdata.ext_start) >= r_len) begin
                    n_res.granted_address = r_rdata.ext_start;
                    if (r_rdata.ext_start + r_len == r_rdata.ext_end) begin
                        n_state = S_RM_RD;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wd  = '{ext_start: r_rdata.ext_start + r_len,
                                    ext_end: r_rdata.ext_end};
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur   = r_rdata;
                    n_idx   = idx_p1;
                    n_state = S_A_RD;
                end
            end
            S_NOFIT: begin
                // r_cur holds the last extent when the table is not empty
                n_touch = (r_count != '0) && (r_cur.ext_end == r_top);
                n_need  = n_touch ? (r_len - (r_top - r_cur.ext_start)) : r_len;
                n_step  = (r_grow_step == '0) ? AW'(1) : r_grow_step;
                n_rem   = '0;
                n_bit   = 5'(AW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = (rem2 >= {1'b0, r_step}) ? AW'(rem2 - {1'b0, r_step})
                                                 : rem2[AW-1:0];
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_G1;
                end
            end
            S_G1: begin
                // Round the shortfall up to whole steps, at least one
                if (r_need == '0) begin
                    n_grow = {2'b00, r_step};
                end else begin
                    n_grow = {2'b00, r_need} - {2'b00, r_rem}
                           + ((r_rem != '0) ? {2'b00, r_step} : '0);
                end
                n_state = S_G2;
            end
            S_G2: begin
                n_state = S_DONE;
                if (top_sum > {2'b00, {AW{1'b1}}} || hsize > r_heap_limit) begin
                    n_res.status = ffea_pkg::ST_NO_MEM;
                end else if (!r_touch && at_cap) begin
                    n_res.status = ffea_pkg::ST_FULL;
                end else begin
                    n_top                 = new_top;
                    n_res.granted_address = ext_s;
                    mem_wa                = r_touch ? cnt_m1[IW-1:0] : r_count[IW-1:0];
                    mem_wd                = '{ext_start: cut_s, ext_end: new_top};
                    if (cut_s == new_top) begin
                        n_count = r_touch ? cnt_m1 : r_count;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_touch ? r_count : r_count + 1'b1;
                    end
                end
            end
            S_F_PRE: begin
                n_fend  = fend_w[AW-1:0];
                n_state = S_F_RD;
                if (r_len == '0) begin
                    n_state = S_DONE;
                end else if (fend_w[AW] || fend_w[AW-1:0] > r_top) begin
                    n_res.status = ffea_pkg::ST_OVERLAP;
                    n_state      = S_DONE;
                end
            end
            S_F_RD: begin
                n_rvalid = 1'b0;
                n_state  = (r_idx < r_count) ? S_F_CHK : S_F_DEC;
            end
            S_F_CHK: begin
                if (r_rdata.ext_start < r_addr) begin
                    n_cur   = r_rdata;
                    n_idx   = idx_p1;
                    n_state = S_F_RD;
                end else begin
                    n_right  = r_rdata;
                    n_rvalid = 1'b1;
                    n_state  = S_F_DEC;
                end
            end
            S_F_DEC: begin
                n_state = S_DONE;
                if ((r_idx != '0 && r_cur.ext_end > r_addr)
                    || (r_rvalid && r_fend > r_right.ext_start)) begin
                    n_res.status = ffea_pkg::ST_OVERLAP;
                end else if (r_idx != '0 && r_cur.ext_end == r_addr) begin
                    mem_we = 1'b1;
                    mem_wa = idx_m1[IW-1:0];
                    if (r_rvalid && r_right.ext_start == r_fend) begin
                        // Bridge both neighbors, then drop the right one
                        mem_wd  = '{ext_start: r_cur.ext_start, ext_end: r_right.ext_end};
                        n_state = S_RM_RD;
                    end else begin
                        mem_wd = '{ext_start: r_cur.ext_start, ext_end: r_fend};
                    end
                end else if (r_rvalid && r_right.ext_start == r_fend) begin
                    mem_we = 1'b1;
                    mem_wd = '{ext_start: r_addr, ext_end: r_right.ext_end};
                end else if (at_cap) begin
                    n_res.status = ffea_pkg::ST_FULL;
                end else begin
                    n_k     = r_count;
                    n_state = S_IN_RD;
                end
            end
            S_RM_RD: begin
                mem_ra = idx_p1[IW-1:0];
                if (idx_p1 < r_count) begin
                    n_state = S_RM_WR;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_DONE;
                end
            end
            S_RM_WR: begin
                mem_we  = 1'b1;
                n_idx   = idx_p1;
                n_state = S_RM_RD;
            end
            S_IN_RD: begin
                mem_ra = k_m1[IW-1:0];
                if (r_k > r_idx) begin
                    n_state = S_IN_WR;
                end else begin
                    mem_we  = 1'b1;
                    mem_wd  = '{ext_start: r_addr, ext_end: r_fend};
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_IN_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_k[IW-1:0];
                n_k     = k_m1;
                n_state = S_IN_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_res.status != ffea_pkg::ST_OK) begin
            n_res.granted_address = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_count   <= '0;
            r_top     <= '0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_count   <= n_count;
            r_top     <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_fend   <= n_fend;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_right  <= n_right;
        r_rvalid <= n_rvalid;
        r_touch  <= n_touch;
        r_need   <= n_need;
        r_step   <= n_step;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_grow   <= n_grow;
        r_res    <= n_res;
    end

endmodule

// ===== hdl/ffea_checker.sv =====
// Port-level checks of the first-fit extent allocator, bound to the top level.
module ffea_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input ffea_pkg::t_result o_result
);

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // A result only comes from a request in progress
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy && $past(busy))
        else $error("result strobe without a request in progress");

    // Each request gives one result, then the block goes idle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid && !busy)
        else $error("result strobe longer than one cycle");

    // Errors grant no address
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status != ffea_pkg::ST_OK
            |-> o_result.granted_address == '0)
        else $error("error result with nonzero address");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (.*);
